[hdl/irfse_pkg.sv]
// irfse_pkg: shared types, codes and byte tables of the infrared frame script encoder
// used by every module of the encoder; depends on nothing

package irfse_pkg;

	// protocol selector codes on the command port
	localparam logic [1:0] CMD_RC6  = 2'd0;
	localparam logic [1:0] CMD_SONY = 2'd1;
	localparam logic [1:0] CMD_NEC  = 2'd2;
	localparam logic [1:0] CMD_NONE = 2'd3;

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	localparam int DATA_W = 32;
	localparam int STEP_W = 6;

	typedef enum logic [1:0] {
		KIND_RC6  = 2'd0,
		KIND_SONY = 2'd1,
		KIND_NEC  = 2'd2
	} kind_t;

	// one classified frame waiting for the back end
	typedef struct packed {
		kind_t             kind;
		logic              toggle;
		logic [DATA_W-1:0] data;
	} frame_t;

	// step ranges of each frame layout
	localparam logic [STEP_W-1:0] RC6_TOGGLE_STEP = 6'd5;
	localparam logic [STEP_W-1:0] RC6_DATA_FIRST  = 6'd6;
	localparam logic [STEP_W-1:0] RC6_DATA_LAST   = 6'd13;
	localparam logic [STEP_W-1:0] RC6_LAST_STEP   = 6'd17;
	localparam logic [STEP_W-1:0] SONY_DATA_FIRST = 6'd3;
	localparam logic [STEP_W-1:0] SONY_DATA_LAST  = 6'd12;
	localparam logic [STEP_W-1:0] SONY_LAST_STEP  = 6'd15;
	localparam logic [STEP_W-1:0] NEC_DATA_FIRST  = 6'd4;
	localparam logic [STEP_W-1:0] NEC_DATA_LAST   = 6'd35;
	localparam logic [STEP_W-1:0] NEC_LAST_STEP   = 6'd43;

	localparam logic [7:0] RC6_SYM [4]  = '{8'h58, 8'h68, 8'h98, 8'hA8};
	localparam logic [7:0] SONY_SYM [4] = '{8'hA8, 8'hD4, 8'hB4, 8'hDA};
	localparam logic [7:0] RC6_TOGGLE_ON  = 8'hC8;
	localparam logic [7:0] RC6_TOGGLE_OFF = 8'h38;
	localparam logic [7:0] NEC_ONE  = 8'h88;
	localparam logic [7:0] NEC_ZERO = 8'hA0;

	function automatic logic [STEP_W-1:0] last_step(kind_t kind);
		logic [STEP_W-1:0] s;
		unique case (kind)
			KIND_RC6:  s = RC6_LAST_STEP;
			KIND_SONY: s = SONY_LAST_STEP;
			KIND_NEC:  s = NEC_LAST_STEP;
			default:   s = RC6_LAST_STEP;
		endcase
		return s;
	endfunction

	function automatic logic is_data_step(kind_t kind, logic [STEP_W-1:0] step);
		logic d;
		unique case (kind)
			KIND_RC6:  d = (step >= RC6_DATA_FIRST) && (step <= RC6_DATA_LAST);
			KIND_SONY: d = (step >= SONY_DATA_FIRST) && (step <= SONY_DATA_LAST);
			KIND_NEC:  d = (step >= NEC_DATA_FIRST) && (step <= NEC_DATA_LAST);
			default:   d = 1'b0;
		endcase
		return d;
	endfunction

	// fixed header and trailer bytes, indexed by step
	function automatic logic [7:0] fixed_byte(kind_t kind, logic [STEP_W-1:0] step);
		logic [7:0] b;
		b = 8'h00;
		unique case (kind)
			KIND_RC6: begin
				unique case (step)
					6'd0:    b = 8'h5D;
					6'd1:    b = 8'h10;
					6'd2:    b = 8'hFE;
					6'd3:    b = 8'h28;
					6'd4:    b = 8'h56;
					6'd14:   b = 8'h65;
					6'd15:   b = 8'h65;
					6'd16:   b = 8'h80;
					6'd17:   b = 8'h0E;
					default: b = 8'h00;
				endcase
			end
			KIND_SONY: begin
				unique case (step)
					6'd0:    b = 8'h53;
					6'd1:    b = 8'h18;
					6'd2:    b = 8'hF4;
					6'd13:   b = 8'h27;
					6'd14:   b = 8'h80;
					6'd15:   b = 8'h0C;
					default: b = 8'h00;
				endcase
			end
			KIND_NEC: begin
				unique case (step)
					6'd0:    b = 8'h58;
					6'd1:    b = 8'h15;
					6'd2:    b = 8'hA1;
					6'd3:    b = 8'h11;
					6'd36:   b = 8'h82;
					6'd37:   b = 8'h7F;
					6'd38:   b = 8'hA1;
					6'd39:   b = 8'hA0;
					6'd40:   b = 8'h6D;
					6'd41:   b = 8'h6D;
					6'd42:   b = 8'h80;
					6'd43:   b = 8'h05;
					default: b = 8'h00;
				endcase
			end
			default: b = 8'h00;
		endcase
		return b;
	endfunction

	// byte for one step; sym is the low end of the data shifter
	function automatic logic [7:0] frame_byte(kind_t kind, logic [STEP_W-1:0] step,
			logic toggle, logic [1:0] sym);
		logic [7:0] b;
		if (kind == KIND_RC6 && step == RC6_TOGGLE_STEP) begin
			b = toggle ? RC6_TOGGLE_ON : RC6_TOGGLE_OFF;
		end else if (is_data_step(kind, step)) begin
			unique case (kind)
				KIND_RC6:  b = RC6_SYM[sym];
				KIND_SONY: b = SONY_SYM[sym];
				KIND_NEC:  b = sym[0] ? NEC_ONE : NEC_ZERO;
				default:   b = 8'h00;
			endcase
		end else begin
			b = fixed_byte(kind, step);
		end
		return b;
	endfunction

endpackage

[hdl/ir_remote_frame_script_encoder.sv]
// ir_remote_frame_script_encoder: top level of the infrared frame script encoder
// joins front, frame queue and byte sequencer; depends on irfse_pkg and the irfse modules
//
//   channel   handshake            payload
//   input     in_valid / in_stall  command, address, key_code, extension
//   output    out_valid/out_stall  script_byte, last
//
// one script byte per cycle while the output is not stalled: an rc6 frame has 18 bytes,
// sony 16, nec 44; between frames the sequencer goes idle to load the next one from the queue
// the queue holds two frames, so key presses are taken while a frame is sent
// a selector of 3 is taken and dropped without any byte
// output stall holds the byte register; the sequencer waits behind it
// arst_n clears the toggle, the queue and the sequencer

module ir_remote_frame_script_encoder (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [1:0] command,
	input  logic [7:0] address,
	input  logic [7:0] key_code,
	input  logic [7:0] extension,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] script_byte,
	output logic       last
);
	import irfse_pkg::*;

	frame_t push_frame;
	frame_t pop_frame;
	logic   q_push;
	logic   q_ready;
	logic   q_pop;
	logic   q_valid;

	irfse_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.command   (command),
		.address   (address),
		.key_code  (key_code),
		.extension (extension),
		.q_ready   (q_ready),
		.q_push    (q_push),
		.q_frame   (push_frame)
	);

	irfse_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_frame (push_frame),
		.ready      (q_ready),
		.pop        (q_pop),
		.valid      (q_valid),
		.pop_frame  (pop_frame)
	);

	irfse_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_valid     (q_valid),
		.q_frame     (pop_frame),
		.q_pop       (q_pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.script_byte (script_byte),
		.last        (last)
	);

endmodule

[hdl/irfse_front.sv]
// irfse_front: accepts key presses, keeps the rc6 toggle and packs each frame's data
// so that the back end always shifts toward the lsb; depends on irfse_pkg

module irfse_front (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [1:0]            command,
	input  logic [7:0]            address,
	input  logic [7:0]            key_code,
	input  logic [7:0]            extension,
	input  logic                  q_ready,
	output logic                  q_push,
	output irfse_pkg::frame_t     q_frame
);
	import irfse_pkg::*;

	logic        rc6_toggle_q;
	logic        accept;
	logic [15:0] rc6_word;
	logic [DATA_W-1:0] rc6_data;

	assign in_stall = !q_ready;
	assign accept   = in_valid && q_ready;
	assign q_push   = accept && (command != CMD_NONE);

	// rc6 goes out msb first two bits at a time: reverse the pair order
	assign rc6_word = {address, key_code};
	always_comb begin
		rc6_data = '0;
		for (int i = 0; i < 8; i++) begin
			rc6_data[2*i +: 2] = rc6_word[15 - 2*i -: 2];
		end
	end

	always_comb begin
		q_frame.kind   = KIND_RC6;
		q_frame.toggle = !rc6_toggle_q;
		q_frame.data   = rc6_data;
		unique case (command)
			CMD_SONY: begin
				q_frame.kind = KIND_SONY;
				q_frame.data = {12'd0, extension, address[4:0], key_code[6:0]};
			end
			CMD_NEC: begin
				q_frame.kind = KIND_NEC;
				q_frame.data = {~key_code, key_code, ~address, address};
			end
			default: begin
				q_frame.kind = KIND_RC6;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rc6_toggle_q <= 1'b0;
		end else if (accept && command == CMD_RC6) begin
			rc6_toggle_q <= !rc6_toggle_q;
		end
	end

endmodule

[hdl/irfse_queue.sv]
// irfse_queue: small frame queue between the front and the back end
// depends on irfse_pkg for the frame type and depth

module irfse_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  irfse_pkg::frame_t push_frame,
	output logic              ready,
	input  logic              pop,
	output logic              valid,
	output irfse_pkg::frame_t pop_frame
);
	import irfse_pkg::*;

	frame_t              mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q;
	logic [QPTR_W-1:0]   rd_ptr_q;
	logic [QCNT_W-1:0]   count_q;

	assign ready     = count_q != QCNT_W'(QUEUE_DEPTH);
	assign valid     = count_q != '0;
	assign pop_frame = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_frame;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

[hdl/irfse_back.sv]
// irfse_back: byte sequencer that walks one frame's layout and feeds the output register
// depends on irfse_pkg for the frame type and the byte tables

module irfse_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              q_valid,
	input  irfse_pkg::frame_t q_frame,
	output logic              q_pop,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [7:0]        script_byte,
	output logic              last
);
	import irfse_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_RUN  = 2'b10
	} state_t;

	state_t            state_q;
	kind_t             kind_q;
	logic              toggle_q;
	logic [DATA_W-1:0] sh_q;
	logic [STEP_W-1:0] step_q;
	logic              out_valid_q;
	logic [7:0]        byte_q;
	logic              last_q;

	logic              advance;
	logic              at_last;
	logic              data_step;

	assign q_pop     = (state_q == ST_IDLE) && q_valid;
	assign advance   = (state_q == ST_RUN) && (!out_valid_q || !out_stall);
	assign at_last   = step_q == last_step(kind_q);
	assign data_step = is_data_step(kind_q, step_q);

	assign out_valid   = out_valid_q;
	assign script_byte = byte_q;
	assign last        = last_q;

	always_ff @(posedge clk) begin
		if (q_pop) begin
			kind_q   <= q_frame.kind;
			toggle_q <= q_frame.toggle;
			sh_q     <= q_frame.data;
		end else if (advance && data_step) begin
			// nec spends one bit per byte, the others a two-bit symbol
			sh_q <= (kind_q == KIND_NEC) ? (sh_q >> 1) : (sh_q >> 2);
		end
		if (advance) begin
			byte_q <= frame_byte(kind_q, step_q, toggle_q, sh_q[1:0]);
			last_q <= at_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (q_valid) begin
						state_q <= ST_RUN;
						step_q  <= '0;
					end
				end
				ST_RUN: begin
					if (advance) begin
						step_q <= step_q + 1'b1;
						if (at_last) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

[hdl/irfse_checker.sv]
// irfse_checker: port level assertions on the frame script encoder
// bound to ir_remote_frame_script_encoder; depends on nothing else

module irfse_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_stall,
	input logic       out_valid,
	input logic       out_stall,
	input logic [7:0] script_byte,
	input logic       last
);

	// a stalled output transfer holds its byte
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(script_byte) && $stable(last))
		else $error("output byte changed while stalled");

	// an offered byte is always fully defined
	a_out_known: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !$isunknown({script_byte, last}))
		else $error("unknown bits on an offered byte");

	// the queue only fills up after a taken key press
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(in_stall) |-> $past(in_valid))
		else $error("input stall rose without a transfer");

	// nothing is offered as reset lets go
	a_reset_quiet: assert property (@(posedge clk) $rose(arst_n) |-> !out_valid)
		else $error("output valid right after reset");

endmodule

bind ir_remote_frame_script_encoder irfse_checker u_irfse_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_stall    (in_stall),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.script_byte (script_byte),
	.last        (last)
);
